### rtl/neighbor_tx_power_control_top_assert.svh
// assertion macros for the neighbor transmit power control block
// no dependencies; included by the modules that check their own logic
`ifndef NEIGHBOR_TX_POWER_CONTROL_TOP_ASSERT_SVH
`define NEIGHBOR_TX_POWER_CONTROL_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define NTPC_ASSERT_SAME(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");
`define NTPC_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");
`else
`define NTPC_ASSERT_SAME(label, clk, rst, cond, prop)
`define NTPC_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

### rtl/ntpc_pkg.sv
// types and constants shared by the neighbor transmit power control block
// no dependencies
package ntpc_pkg;

   localparam logic [1:0] CMD_LOST      = 2'd0;
   localparam logic [1:0] CMD_DELIVERED = 2'd1;

   localparam logic [1:0] CSR_POWER_TOP     = 2'd0;
   localparam logic [1:0] CSR_POWER_BOTTOM  = 2'd1;
   localparam logic [1:0] CSR_SUCCESS_LIMIT = 2'd2;
   localparam logic [1:0] CSR_LOSS_LIMIT    = 2'd3;

   localparam logic [4:0] POWER_TOP_RESET     = 5'd30;
   localparam logic [4:0] POWER_BOTTOM_RESET  = 5'd1;
   localparam logic [3:0] SUCCESS_LIMIT_RESET = 4'd1;
   localparam logic [3:0] LOSS_LIMIT_RESET    = 4'd10;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] neighbor_addr;
   } req_type;

   typedef struct packed {
      logic [4:0] tx_power;
      logic       new_entry;
      logic       table_full;
   } rsp_type;

   typedef struct packed {
      logic       first_phase;
      logic [3:0] success_count;
      logic [3:0] loss_count;
      logic [4:0] power;
   } entry_type;

   typedef struct packed {
      logic [4:0] power_top;
      logic [4:0] power_bottom;
      logic [3:0] success_limit;
      logic [3:0] loss_limit;
   } cfg_type;

   typedef enum logic {
      NTPC_IDLE,
      NTPC_UPDATE
   } state_type;

endpackage

### rtl/neighbor_tx_power_control_top.sv
// one request at a time: no new request is taken until the previous update is done;
// address compare and entry read in the accept cycle, then read-modify-write of the
// entry memory; a response not taken stalls the update
// reset clears the slot valid bits, config registers, state and the response valid flag;
// the entry memory is not cleared
// top level: address match flops, entry memory, sequencer and response register
// depends on ntpc_pkg, ntpc_update and neighbor_tx_power_control_top_assert.svh
`include "neighbor_tx_power_control_top_assert.svh"
module neighbor_tx_power_control_top #(
   parameter int NEIGHBOR_SLOTS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ntpc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ntpc_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [4:0]        csr_data
);

   localparam int SLOT_W = (NEIGHBOR_SLOTS > 1) ? $clog2(NEIGHBOR_SLOTS) : 1;

   ntpc_pkg::cfg_type   cfg_ff;
   ntpc_pkg::state_type state_ff, state_in;

   logic [NEIGHBOR_SLOTS-1:0] valid_ff;
   logic [7:0]                addr_ff [NEIGHBOR_SLOTS];
   ntpc_pkg::entry_type       mem [NEIGHBOR_SLOTS];
   ntpc_pkg::entry_type       mem_rd_ff;
   ntpc_pkg::entry_type       entry_wr;

   logic              hit, free_found;
   logic [SLOT_W-1:0] hit_idx, free_idx;
   logic              hit_ff, free_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [1:0]        cmd_ff;
   logic [7:0]        naddr_ff;

   logic              req_fire, update_fire, alloc, full;
   logic              rsp_valid_ff;
   ntpc_pkg::rsp_type rsp_data_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.power_top     <= ntpc_pkg::POWER_TOP_RESET;
         cfg_ff.power_bottom  <= ntpc_pkg::POWER_BOTTOM_RESET;
         cfg_ff.success_limit <= ntpc_pkg::SUCCESS_LIMIT_RESET;
         cfg_ff.loss_limit    <= ntpc_pkg::LOSS_LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            ntpc_pkg::CSR_POWER_TOP:     cfg_ff.power_top     <= csr_data;
            ntpc_pkg::CSR_POWER_BOTTOM:  cfg_ff.power_bottom  <= csr_data;
            ntpc_pkg::CSR_SUCCESS_LIMIT: cfg_ff.success_limit <= csr_data[3:0];
            ntpc_pkg::CSR_LOSS_LIMIT:    cfg_ff.loss_limit    <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // address match and lowest free slot
   always_comb begin
      hit        = 1'b0;
      hit_idx    = '0;
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NEIGHBOR_SLOTS - 1; i >= 0; i--) begin
         if (valid_ff[i] && addr_ff[i] == req_data.neighbor_addr) begin
            hit     = 1'b1;
            hit_idx = SLOT_W'(i);
         end
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ntpc_pkg::NTPC_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      update_fire = 1'b0;
      unique case (state_ff)
         ntpc_pkg::NTPC_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ntpc_pkg::NTPC_UPDATE;
            end
         end
         ntpc_pkg::NTPC_UPDATE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               update_fire = 1'b1;
               state_in    = ntpc_pkg::NTPC_IDLE;
            end
         end
         default: state_in = ntpc_pkg::NTPC_IDLE;
      endcase
   end

   assign req_fire = req_valid && req_ready;
   assign alloc    = !hit_ff && free_ff;
   assign full     = !hit_ff && !free_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         hit_ff   <= hit;
         free_ff  <= free_found;
         slot_ff  <= hit ? hit_idx : free_idx;
         cmd_ff   <= req_data.cmd;
         naddr_ff <= req_data.neighbor_addr;
      end
   end

   // entry memory
   always_ff @(posedge clock) begin
      if (req_fire) begin
         mem_rd_ff <= mem[hit ? hit_idx : free_idx];
      end
      if (update_fire && !full) begin
         mem[slot_ff] <= entry_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (update_fire && alloc) begin
         valid_ff[slot_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (update_fire && alloc) begin
         addr_ff[slot_ff] <= naddr_ff;
      end
   end

   ntpc_update u_update (
      .cmd      (cmd_ff),
      .is_new   (alloc),
      .cfg      (cfg_ff),
      .entry_rd (mem_rd_ff),
      .entry_wr (entry_wr)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (update_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (update_fire) begin
         rsp_data_ff.tx_power   <= full ? cfg_ff.power_top : entry_wr.power;
         rsp_data_ff.new_entry  <= alloc;
         rsp_data_ff.table_full <= full;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `NTPC_ASSERT_NEXT(a_accept_to_update, clock, reset, req_fire,
                     state_ff == ntpc_pkg::NTPC_UPDATE)
   `NTPC_ASSERT_NEXT(a_alloc_sets_valid, clock, reset, update_fire && alloc,
                     valid_ff[$past(slot_ff)])
   `NTPC_ASSERT_NEXT(a_full_keeps_table, clock, reset, update_fire && full,
                     $stable(valid_ff))
   `NTPC_ASSERT_NEXT(a_update_gives_rsp, clock, reset, update_fire, rsp_valid_ff)
   `NTPC_ASSERT_SAME(a_full_only_when_all_used, clock, reset,
                     update_fire && full, valid_ff == {NEIGHBOR_SLOTS{1'b1}})

endmodule

### rtl/ntpc_update.sv
// per-entry update rule: applies a loss or delivery report to one table entry
// depends on ntpc_pkg
module ntpc_update (
   input  logic [1:0]          cmd,
   input  logic                is_new,
   input  ntpc_pkg::cfg_type   cfg,
   input  ntpc_pkg::entry_type entry_rd,
   output ntpc_pkg::entry_type entry_wr
);

   ntpc_pkg::entry_type base;
   logic [3:0]          loss_next;

   always_comb begin
      if (is_new) begin
         base.first_phase   = 1'b1;
         base.success_count = 4'd0;
         base.loss_count    = 4'd0;
         base.power         = cfg.power_top;
      end else begin
         base = entry_rd;
      end
      loss_next = base.loss_count + 4'd1;
      entry_wr  = base;
      case (cmd)
         ntpc_pkg::CMD_DELIVERED: begin
            if (base.first_phase || base.success_count == cfg.success_limit) begin
               if (base.power > cfg.power_bottom) begin
                  entry_wr.power = base.power - 5'd1;
               end
               entry_wr.success_count = 4'd0;
            end else begin
               entry_wr.success_count = base.success_count + 4'd1;
               entry_wr.loss_count    = 4'd0;
            end
         end
         ntpc_pkg::CMD_LOST: begin
            entry_wr.first_phase   = 1'b0;
            entry_wr.success_count = 4'd0;
            entry_wr.loss_count    = loss_next;
            if (loss_next == cfg.loss_limit) begin
               if (base.power < cfg.power_top) begin
                  entry_wr.power = base.power + 5'd1;
               end
               entry_wr.loss_count = 4'd0;
            end
         end
         default: begin
            entry_wr = base;
         end
      endcase
   end

endmodule
